[sv/atc_pkg.sv]
// ----------------------------------------------------------------------------
// atc_pkg: shared types and constants for the accelerometer tilt core
// Holds pipeline state types, CORDIC arctangent table and sizing constants.
// ----------------------------------------------------------------------------
package atc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NSTAGE        = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int SQRT_STEPS    = 32;

  localparam int CW  = 36;   // CORDIC x/y width
  localparam int ZW  = 33;   // angle accumulator width
  localparam int RW  = 36;   // square-root remainder width
  localparam int SHW = 5;    // shift / step index width
  localparam int SW  = 48;   // sideband: x, y, z samples

  localparam logic signed [ZW-1:0] QUARTER_TURN = 33'sd754974720;
  localparam logic signed [16:0]   PITCH_LIMIT  = 17'sd23040;
  localparam logic signed [16:0]   ROLL_LIMIT   = 17'sd11520;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [31:0]   root;
    logic [31:0]   rad;
    logic [SW-1:0] side;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atc_atan(input int i);
    logic signed [ZW-1:0] a;
    begin
      case (i)
        0:  a = 33'sd377487360;
        1:  a = 33'sd222843801;
        2:  a = 33'sd117744544;
        3:  a = 33'sd59768969;
        4:  a = 33'sd30000467;
        5:  a = 33'sd15014858;
        6:  a = 33'sd7509261;
        7:  a = 33'sd3754860;
        8:  a = 33'sd1877459;
        9:  a = 33'sd938733;
        10: a = 33'sd469367;
        11: a = 33'sd234683;
        12: a = 33'sd117342;
        13: a = 33'sd58671;
        14: a = 33'sd29335;
        15: a = 33'sd14668;
        16: a = 33'sd7334;
        17: a = 33'sd3667;
        18: a = 33'sd1833;
        19: a = 33'sd917;
        20: a = 33'sd458;
        21: a = 33'sd229;
        22: a = 33'sd115;
        23: a = 33'sd57;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

  // Turn a left-half-plane vector into the right half plane.
  function automatic cordic_t atc_prerot(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
    cordic_t c;
    begin
      c.zero = (x == '0) && (y == '0);
      c.x    = x;
      c.y    = y;
      c.z    = '0;
      if (x < 0) begin
        if (y >= 0) begin
          c.x = y;
          c.y = -x;
          c.z = QUARTER_TURN;
        end else begin
          c.x = -y;
          c.y = x;
          c.z = -QUARTER_TURN;
        end
      end
      return c;
    end
  endfunction

  // Round to nearest (ties up), clamp, and force zero for a null vector.
  function automatic logic signed [16:0] atc_round(input cordic_t c,
                                                   input logic signed [16:0] limit);
    logic signed [ZW-1:0] t;
    logic signed [16:0]   r;
    begin
      t = c.z + 33'sd32768;
      r = 17'(t >>> 16);
      if (r > limit)  r = limit;
      if (r < -limit) r = -limit;
      if (c.zero)     r = '0;
      return r;
    end
  endfunction

endpackage

[sv/atc_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// atc_sqrt_cell: one digit step of the pipelined integer square root
// Brings in two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module atc_sqrt_cell import atc_pkg::*; (
  input  logic           clk,
  input  logic           adv,
  input  logic [SHW-1:0] step,
  input  sqrt_t          d_in,
  output sqrt_t          d_out
);

  logic [31:0]   shifted;
  logic [1:0]    pair;
  logic [RW-1:0] rem_s;
  logic [RW-1:0] trial;
  logic          ge;

  // Radicand is rad << 32: the low sixteen bit pairs are zero.
  always_comb begin
    shifted = d_in.rad << {step, 1'b0};
    pair    = step[SHW-1] ? 2'b00 : shifted[31:30];
    rem_s   = {d_in.rem[RW-3:0], pair};
    trial   = {{(RW-34){1'b0}}, d_in.root, 2'b01};
    ge      = (rem_s >= trial);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_out.rem  <= ge ? (rem_s - trial) : rem_s;
      d_out.root <= {d_in.root[30:0], ge};
      d_out.rad  <= d_in.rad;
      d_out.side <= d_in.side;
    end
  end

endmodule

[sv/atc_cordic_cell.sv]
// ----------------------------------------------------------------------------
// atc_cordic_cell: one CORDIC vectoring micro-rotation
// Steers on the sign of y and accumulates the table angle.
// ----------------------------------------------------------------------------
module atc_cordic_cell import atc_pkg::*; (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [SHW-1:0]       shift,
  input  logic signed [ZW-1:0] angle,
  input  cordic_t              d_in,
  output cordic_t              d_out
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  assign dx = d_in.y >>> shift;
  assign dy = d_in.x >>> shift;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_out.zero <= d_in.zero;
      if (d_in.y >= 0) begin
        d_out.x <= d_in.x + dx;
        d_out.y <= d_in.y - dy;
        d_out.z <= d_in.z + angle;
      end else begin
        d_out.x <= d_in.x - dx;
        d_out.y <= d_in.y + dy;
        d_out.z <= d_in.z - angle;
      end
    end
  end

endmodule

[sv/accel_tilt_angles_core.sv]
// ----------------------------------------------------------------------------
// accel_tilt_angles_core: pitch and roll from a raw three-axis sample
// Throughput: one beat per cycle while no output stall holds the pipeline;
// every stage is a register, the chains never loop.
// A result beat held by an output stall freezes the whole pipeline in place.
// Reset clears the stage valid bits only; the data path needs no reset.
// ----------------------------------------------------------------------------
module accel_tilt_angles_core import atc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pitch_angle,
  output logic signed [14:0] roll_angle
);

  // Stages: input, squares, sum, square-root cells, pre-rotation, CORDIC cells, output.
  localparam int L = 3 + SQRT_STEPS + 1 + NSTAGE + 1;

  logic         adv;
  logic [L-1:0] vld;

  // Advance everything whenever the output slot is free or being taken.
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // Capture the sample.
  logic signed [15:0] ax, ay, az;
  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= accel_x;
      ay <= accel_y;
      az <= accel_z;
    end
  end

  // Square y and z, then sum the squares; carry the raw sample alongside.
  logic signed [31:0] py, pz;
  logic [31:0]        sqy, sqz;
  logic [SW-1:0]      side1, side2;
  logic [31:0]        rad;

  assign py = ay * ay;
  assign pz = az * az;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqy   <= py;
      sqz   <= pz;
      side1 <= {ax, ay, az};
      rad   <= sqy + sqz;
      side2 <= side1;
    end
  end

  // Square root chain: one root bit per cell, radicand is (y^2 + z^2) << 32.
  sqrt_t sq_st [0:SQRT_STEPS];

  always_comb begin
    sq_st[0].rem  = '0;
    sq_st[0].root = '0;
    sq_st[0].rad  = rad;
    sq_st[0].side = side2;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    atc_sqrt_cell u_cell (
      .clk   (clk),
      .adv   (adv),
      .step  (SHW'(k)),
      .d_in  (sq_st[k]),
      .d_out (sq_st[k+1])
    );
  end

  // Build both vectors in 16 fraction bits and fold them into the right half plane.
  logic signed [15:0]   sx, sy, sz;
  logic signed [CW-1:0] p_x, p_y, r_x, r_y;

  assign {sx, sy, sz} = sq_st[SQRT_STEPS].side;
  assign p_x = {{(CW-32){sz[15]}}, sz, 16'h0000};
  assign p_y = {{(CW-32){sy[15]}}, sy, 16'h0000};
  assign r_x = {{(CW-32){1'b0}}, sq_st[SQRT_STEPS].root};
  assign r_y = -{{(CW-32){sx[15]}}, sx, 16'h0000};

  cordic_t cp [0:NSTAGE];
  cordic_t cr [0:NSTAGE];

  always_ff @(posedge clk) begin
    if (adv) begin
      cp[0] <= atc_prerot(p_x, p_y);
      cr[0] <= atc_prerot(r_x, r_y);
    end
  end

  // CORDIC chains: pitch and roll rotate side by side, one micro-rotation per cell.
  for (genvar i = 0; i < NSTAGE; i++) begin : g_cordic
    atc_cordic_cell u_pitch (
      .clk   (clk),
      .adv   (adv),
      .shift (SHW'(i)),
      .angle (atc_atan(i)),
      .d_in  (cp[i]),
      .d_out (cp[i+1])
    );
    atc_cordic_cell u_roll (
      .clk   (clk),
      .adv   (adv),
      .shift (SHW'(i)),
      .angle (atc_atan(i)),
      .d_in  (cr[i]),
      .d_out (cr[i+1])
    );
  end

  // Round, clamp and hold the result in the output register.
  logic signed [16:0] p_r, r_r;
  assign p_r = atc_round(cp[NSTAGE], PITCH_LIMIT);
  assign r_r = atc_round(cr[NSTAGE], ROLL_LIMIT);

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_angle <= p_r[15:0];
      roll_angle  <= r_r[14:0];
    end
  end

endmodule

[sv/atc_checker.sv]
// ----------------------------------------------------------------------------
// atc_checker: port-level checks on the tilt core
// Watches the handshake and the result ranges; bound to the top level.
// ----------------------------------------------------------------------------
module atc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] pitch_angle,
  input logic signed [14:0] roll_angle
);

  // A stalled result beat stays.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  // Input stalls exactly when a result is held back.
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output back-pressure");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 16'sd23040 && pitch_angle >= -16'sd23040))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_angle <= 15'sd11520 && roll_angle >= -15'sd11520))
    else $error("roll out of range");

endmodule

bind accel_tilt_angles_core atc_checker u_atc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pitch_angle (pitch_angle),
  .roll_angle  (roll_angle)
);
